@@ hdl/bslp_pkg.sv @@
// shared types and constants for the button short/long press detector
`default_nettype none

package bslp_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_BITS       = 16;
  localparam int unsigned CFG_ADDR_BITS  = 2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_BITS-1:0] BOOT_GRACE_RST = 16'd1000;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_BOOT_GRACE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ticks;
    logic [CFG_BITS-1:0] long_press_ticks;
    logic [CFG_BITS-1:0] boot_grace_ticks;
  } cfg_t;

  typedef struct packed {
    logic long_event;
    logic short_event;
  } events_t;

endpackage

`default_nettype wire

@@ hdl/button_short_long_press_detector.sv @@
// Button short/long press detector. Each input word is one millisecond tick with the raw
// active-low button level in tdata bit 0; each tick yields exactly one result word with
// short_event in bit 0 and long_event in bit 1. A tick passes through an input register,
// then the state machine and counters update while the result is loaded into the output
// register, so a word enters every cycle unless stalled. The user must write thresholds
// to the cfg port (0 debounce, 1 long press, 2 boot grace) only while idle, unenforced.
`default_nettype none

module button_short_long_press_detector import bslp_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire [CFG_BITS-1:0]      cfg_data_i,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire [7:0]               s_axis_tdata,  // [0] pin_level, [7:1] zero
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output logic [7:0]              m_axis_tdata   // [0] short_event, [1] long_event, [7:2] zero
);

  cfg_t    cfg_q;
  logic    in_valid_q;
  logic    in_level_q;
  logic    out_ready;
  logic    advance;
  events_t ev;
  events_t out_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEBOUNCE_RST;
      cfg_q.long_press_ticks <= LONG_PRESS_RST;
      cfg_q.boot_grace_ticks <= BOOT_GRACE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data_i;
        CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        CFG_BOOT_GRACE: cfg_q.boot_grace_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
    end
  end

  bslp_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .tick_i  (advance),
    .level_i (in_level_q),
    .events_o(ev)
  );

  bslp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid_q),
    .events_i(ev),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .taken_i (m_axis_tready),
    .events_o(out_ev)
  );

  assign m_axis_tdata = {6'b0, out_ev.long_event, out_ev.short_event};

endmodule

`default_nettype wire

@@ hdl/bslp_fsm.sv @@
// press state machine with saturating tick counters
`default_nettype none

module bslp_fsm import bslp_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  cfg_t    cfg_i,
  input  wire     tick_i,
  input  wire     level_i,
  output events_t events_o
);

  localparam int unsigned CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  typedef enum logic [1:0] {
    MODE_BOOT = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_HELD = 2'd2,
    MODE_LONG = 2'd3
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic                  last_level_q;
  logic [TIMER_BITS-1:0] since_change_q, since_change_d;
  logic [TIMER_BITS-1:0] since_boot_q, since_boot_d;
  logic [TIMER_BITS-1:0] press_time_q, press_time_d;
  logic                  need_release_q, need_release_d;
  logic                  stable;
  events_t               ev;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [CW-1:0] ext_t(input logic [TIMER_BITS-1:0] v);
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] ext_c(input logic [CFG_BITS-1:0] v);
    return CW'(v);
  endfunction

  always_comb begin
    mode_d         = mode_q;
    need_release_d = need_release_q;
    press_time_d   = press_time_q;
    since_boot_d   = sat_inc(since_boot_q);
    since_change_d = (level_i != last_level_q) ? '0 : sat_inc(since_change_q);
    stable         = ext_t(since_change_d) >= ext_c(cfg_i.debounce_ticks);
    ev             = '0;
    case (mode_q)
      MODE_BOOT: begin
        if (ext_t(since_boot_d) >= ext_c(cfg_i.boot_grace_ticks)) begin
          since_change_d = '0;
          need_release_d = ~level_i;
          mode_d         = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        if (stable && level_i) begin
          need_release_d = 1'b0;
        end
        if (stable && !level_i && !need_release_q) begin
          press_time_d = '0;
          mode_d       = MODE_HELD;
        end
      end
      MODE_HELD: begin
        press_time_d = sat_inc(press_time_q);
        if (level_i) begin
          ev.short_event = 1'b1;
          mode_d         = MODE_IDLE;
        end else if (ext_t(press_time_d) >= ext_c(cfg_i.long_press_ticks)) begin
          ev.long_event = 1'b1;
          mode_d        = MODE_LONG;
        end
      end
      default: begin
        if (level_i) begin
          mode_d = MODE_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_BOOT;
      last_level_q   <= 1'b1;
      since_change_q <= '0;
      since_boot_q   <= '0;
      press_time_q   <= '0;
      need_release_q <= 1'b0;
    end else if (tick_i) begin
      mode_q         <= mode_d;
      last_level_q   <= level_i;
      since_change_q <= since_change_d;
      since_boot_q   <= since_boot_d;
      press_time_q   <= press_time_d;
      need_release_q <= need_release_d;
    end
  end

  assign events_o = tick_i ? ev : '0;

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(events_o.short_event && events_o.long_event))
    else $error("short and long event in the same tick");

  a_short_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    events_o.short_event |=> mode_q == MODE_IDLE)
    else $error("short event did not return to idle");

  a_long_to_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    events_o.long_event |=> mode_q == MODE_LONG)
    else $error("long event did not enter long fired");

  a_held_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HELD |-> !need_release_q)
    else $error("held while a release is still required");

endmodule

`default_nettype wire

@@ hdl/bslp_out_reg.sv @@
// result register on the master side
`default_nettype none

module bslp_out_reg import bslp_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     load_i,
  input  events_t events_i,
  output logic    ready_o,
  output logic    valid_o,
  input  wire     taken_i,
  output events_t events_o
);

  logic    valid_q;
  events_t events_q;

  assign ready_o = !valid_q || taken_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      events_q <= events_i;
    end
  end

  assign valid_o  = valid_q;
  assign events_o = events_q;

endmodule

`default_nettype wire

@@ test/button_short_long_press_detector_tb.sv @@
// testbench for the button short/long press detector: tick stream in, event words checked
module button_short_long_press_detector_tb;
  import bslp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TB = TIMER_BITS_DEF;
  localparam logic [TB-1:0] TIMER_MAX = '1;
  // no register lives at this index; writes there must be dropped
  localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic [1:0] {
    M_BOOT = 2'd0,
    M_IDLE = 2'd1,
    M_HELD = 2'd2,
    M_LONG = 2'd3
  } btn_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i = '0;
  logic [CFG_BITS-1:0]      cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;   // [0] pin_level, [7:1] zero
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;        // [0] short_event, [1] long_event, [7:2] zero

  button_short_long_press_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // detector state as the block should hold it
  logic [CFG_BITS-1:0] deb_ticks, long_ticks, grace_ticks;
  btn_mode_e           btn_mode;
  logic                prev_level;
  logic [TB-1:0]       stable_age, boot_age, hold_age;
  logic                wait_release;

  events_t     expected_events[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  bit          idle_en = 1'b0;
  bit          stall_en = 1'b0;
  int unsigned ready_hold = 0;

  function automatic logic [TB-1:0] sat_inc(input logic [TB-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  function automatic events_t step_detector(input logic level);
    events_t ev;
    logic    stable;
    ev = '0;
    boot_age = sat_inc(boot_age);
    stable_age = (level != prev_level) ? '0 : sat_inc(stable_age);
    prev_level = level;
    stable = stable_age >= deb_ticks;
    case (btn_mode)
      M_BOOT: begin
        if (boot_age >= grace_ticks) begin
          stable_age = '0;
          wait_release = ~level;
          btn_mode = M_IDLE;
        end
      end
      M_IDLE: begin
        if (stable && level) wait_release = 1'b0;
        if (stable && !level && !wait_release) begin
          hold_age = '0;
          btn_mode = M_HELD;
        end
      end
      M_HELD: begin
        hold_age = sat_inc(hold_age);
        if (level) begin
          ev.short_event = 1'b1;
          btn_mode = M_IDLE;
        end else if (hold_age >= long_ticks) begin
          ev.long_event = 1'b1;
          btn_mode = M_LONG;
        end
      end
      default: begin
        if (level) btn_mode = M_IDLE;
      end
    endcase
    return ev;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random backpressure on the result side
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      ready_hold <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_events
    events_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = events_t'(m_axis_tdata[1:0]);
      if (expected_events.size() == 0) begin
        $error("event word with no tick waiting for it: %b", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (got.short_event !== want.short_event) begin
          $error("short_event: expected %0b, got %0b", want.short_event, got.short_event);
          mismatches++;
        end
        if (got.long_event !== want.long_event) begin
          $error("long_event: expected %0b, got %0b", want.long_event, got.long_event);
          mismatches++;
        end
      end
    end
  end

  // one tick word; returns at the edge where it was taken
  task automatic send_tick(input logic level);
    int unsigned gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_events.push_back(step_detector(level));
    ticks_sent++;
  endtask

  task automatic send_level(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE:   deb_ticks = val;
      CFG_LONG_PRESS: long_ticks = val;
      CFG_BOOT_GRACE: grace_ticks = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // button held through a short boot grace, then plain presses
  task automatic test_boot_held_press();
    write_reg(CFG_BOOT_GRACE, 16'd40);
    write_reg(CFG_DEBOUNCE, 16'd5);
    write_reg(CFG_LONG_PRESS, 16'd60);
    idle_en = 1'b1;
    stall_en = 1'b1;
    send_level(1'b0, 60);
    send_level(1'b1, 10);
    send_level(1'b0, 3);    // shorter than debounce: ignored
    send_level(1'b1, 8);
    send_level(1'b0, 80);
    send_level(1'b1, 10);
    send_level(1'b0, 20);
    send_level(1'b1, 5);
  endtask

  task automatic test_zero_thresholds();
    drain();
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG_PRESS, 16'd0);
    send_level(1'b1, 3);
    send_level(1'b0, 3);
    send_level(1'b1, 2);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_register_index();
    drain();
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    write_reg(CFG_BOOT_GRACE, 16'd0);
    write_reg(CFG_BOOT_GRACE, 16'hFFFF);
    send_level(1'b0, 2);
    send_level(1'b1, 2);
    drain();
    write_reg(CFG_DEBOUNCE, 16'd1);
    write_reg(CFG_LONG_PRESS, 16'd1);
    send_level(1'b0, 2);
    send_level(1'b1, 2);
    send_level(1'b0, 3);
    send_level(1'b1, 1);
    send_level(1'b0, 4);
    send_level(1'b1, 3);
  endtask

  // all-ones thresholds: a long low level never arms a press
  task automatic test_large_thresholds();
    drain();
    idle_en = 1'b0;
    stall_en = 1'b0;
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    send_level(1'b1, 5);
    send_level(1'b0, 150);
    send_level(1'b1, 3);
  endtask

  task automatic run_press();
    int unsigned n_bounce, n_low, n_high, cap;
    cap = deb_ticks + long_ticks + 4;
    if (cap > 200) cap = 200;
    n_bounce = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    repeat (n_bounce) send_tick(1'($urandom_range(0, 1)));
    n_low = $urandom_range(0, cap);
    send_level(1'b0, n_low);
    cap = deb_ticks + 3;
    if (cap > 100) cap = 100;
    n_high = $urandom_range(0, cap);
    send_level(1'b1, n_high);
  endtask

  task automatic test_random_presses();
    int unsigned phase, stop_at;
    bit          mid_drained;
    for (phase = 0; phase < 6; phase++) begin
      drain();
      idle_en = (phase != 1);
      stall_en = (phase != 1);
      mid_drained = 1'b0;
      if (phase == 0) begin
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_LONG_PRESS, 16'd1);
      end else begin
        write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 10)));
        write_reg(CFG_LONG_PRESS, 16'($urandom_range(0, 30)));
      end
      write_reg(CFG_BOOT_GRACE, 16'($urandom_range(0, 16'hFFFF)));
      stop_at = ticks_sent + 130;
      while (ticks_sent < stop_at) begin
        // sender holds off until the pipe is empty, then resumes
        if (phase == 2 && !mid_drained && ticks_sent + 65 >= stop_at) begin
          drain();
          mid_drained = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          run_press();
        end
      end
    end
  endtask

  initial begin
    deb_ticks = DEBOUNCE_RST;
    long_ticks = LONG_PRESS_RST;
    grace_ticks = BOOT_GRACE_RST;
    btn_mode = M_BOOT;
    prev_level = 1'b1;
    stable_age = '0;
    boot_age = '0;
    hold_age = '0;
    wait_release = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boot_held_press();
    test_zero_thresholds();
    test_register_index();
    test_large_thresholds();
    test_random_presses();
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
